### sv/line_point_generator_defines.svh
// ----------------------------------------------------------------------------
// Line point generator assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef LINE_POINT_GENERATOR_DEFINES_SVH
`define LINE_POINT_GENERATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LPG_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LPG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/lpg_pkg.sv
// ----------------------------------------------------------------------------
// Line point generator package
// Shared constants, action and direction codes, and the status bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package lpg_pkg;

  localparam int unsigned COORD_BITS_DEF = 11;
  localparam int unsigned COLOR_BITS     = 16;

  // Action field of an input item.
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_STEP = 1'b1;

  // Step direction of one axis.
  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_INC  = 2'd1;
  localparam logic [1:0] DIR_DEC  = 2'd3;

  // Status of the stepping core toward the top level.
  typedef struct packed {
    logic valid;  // a pixel is produced by the item taken this cycle
    logic last;   // that pixel ends the line
    logic busy;   // a line is in progress
  } lpg_stat_t;

endpackage

`default_nettype wire

### sv/lpg_in_if.sv
// ----------------------------------------------------------------------------
// Line point generator input channel
// Valid/ready channel carrying one load or step item.
// ----------------------------------------------------------------------------
`default_nettype none

interface lpg_in_if #(
  parameter int unsigned CoordBits = 11
);
  logic                 valid;
  logic                 ready;
  logic                 action;
  logic [CoordBits-1:0] x_start;
  logic [CoordBits-1:0] y_start;
  logic [CoordBits-1:0] x_end;
  logic [CoordBits-1:0] y_end;

  modport source (
    output valid, action, x_start, y_start, x_end, y_end,
    input  ready
  );

  modport sink (
    input  valid, action, x_start, y_start, x_end, y_end,
    output ready
  );
endinterface

`default_nettype wire

### sv/lpg_out_if.sv
// ----------------------------------------------------------------------------
// Line point generator output channel
// Valid/ready channel carrying one plotted pixel.
// ----------------------------------------------------------------------------
`default_nettype none

interface lpg_out_if #(
  parameter int unsigned CoordBits = 11
);
  logic                 valid;
  logic                 ready;
  logic [CoordBits-1:0] pixel_x;
  logic [CoordBits-1:0] pixel_y;
  logic [15:0]          pixel_color;
  logic                 last;

  modport source (
    output valid, pixel_x, pixel_y, pixel_color, last,
    input  ready
  );

  modport sink (
    input  valid, pixel_x, pixel_y, pixel_color, last,
    output ready
  );
endinterface

`default_nettype wire

### sv/lpg_step.sv
// ----------------------------------------------------------------------------
// Line point generator stepping core
// Holds the line state and advances it by one load or one step per item.
// ----------------------------------------------------------------------------
`default_nettype none

module lpg_step import lpg_pkg::*; #(
  parameter int unsigned CoordBits = COORD_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 take_i,
  input  logic                 action_i,
  input  logic [CoordBits-1:0] x_start_i,
  input  logic [CoordBits-1:0] y_start_i,
  input  logic [CoordBits-1:0] x_end_i,
  input  logic [CoordBits-1:0] y_end_i,
  output logic [CoordBits-1:0] pixel_x_o,
  output logic [CoordBits-1:0] pixel_y_o,
  output lpg_stat_t            stat_o
);

  localparam int unsigned ErrBits = CoordBits + 1;

  logic [CoordBits-1:0] cur_col_q, cur_col_d, cur_row_q, cur_row_d;
  logic [ErrBits-1:0]   col_err_q, col_err_d, row_err_q, row_err_d;
  logic [CoordBits-1:0] abs_dx_q, abs_dx_d, abs_dy_q, abs_dy_d;
  logic [CoordBits-1:0] span_q, span_d;
  logic [1:0]           col_dir_q, col_dir_d, row_dir_q, row_dir_d;
  logic [ErrBits-1:0]   points_left_q, points_left_d;
  logic                 busy_q, busy_d;

  logic [1:0]           col_dir_ld, row_dir_ld;
  logic [CoordBits-1:0] abs_dx_ld, abs_dy_ld, span_ld;
  logic [ErrBits-1:0]   span_w, col_sum, row_sum, pl_dec;
  logic [CoordBits-1:0] col_moved, row_moved;
  logic                 step_fire;

  // Direction and absolute delta of each axis for a load.
  always_comb begin
    if (x_end_i > x_start_i) begin
      col_dir_ld = DIR_INC;
      abs_dx_ld  = x_end_i - x_start_i;
    end else if (x_end_i < x_start_i) begin
      col_dir_ld = DIR_DEC;
      abs_dx_ld  = x_start_i - x_end_i;
    end else begin
      col_dir_ld = DIR_NONE;
      abs_dx_ld  = '0;
    end
    if (y_end_i > y_start_i) begin
      row_dir_ld = DIR_INC;
      abs_dy_ld  = y_end_i - y_start_i;
    end else if (y_end_i < y_start_i) begin
      row_dir_ld = DIR_DEC;
      abs_dy_ld  = y_start_i - y_end_i;
    end else begin
      row_dir_ld = DIR_NONE;
      abs_dy_ld  = '0;
    end
    span_ld = (abs_dx_ld > abs_dy_ld) ? abs_dx_ld : abs_dy_ld;
  end

  always_comb begin
    case (col_dir_q)
      DIR_INC: col_moved = cur_col_q + CoordBits'(1);
      DIR_DEC: col_moved = cur_col_q - CoordBits'(1);
      default: col_moved = cur_col_q;
    endcase
    case (row_dir_q)
      DIR_INC: row_moved = cur_row_q + CoordBits'(1);
      DIR_DEC: row_moved = cur_row_q - CoordBits'(1);
      default: row_moved = cur_row_q;
    endcase
  end

  assign span_w    = {1'b0, span_q};
  assign col_sum   = col_err_q + {1'b0, abs_dx_q};
  assign row_sum   = row_err_q + {1'b0, abs_dy_q};
  assign pl_dec    = points_left_q - ErrBits'(1);
  assign step_fire = take_i && (action_i == ACT_STEP) && busy_q;

  always_comb begin
    cur_col_d     = cur_col_q;
    cur_row_d     = cur_row_q;
    col_err_d     = col_err_q;
    row_err_d     = row_err_q;
    abs_dx_d      = abs_dx_q;
    abs_dy_d      = abs_dy_q;
    span_d        = span_q;
    col_dir_d     = col_dir_q;
    row_dir_d     = row_dir_q;
    points_left_d = points_left_q;
    busy_d        = busy_q;
    if (take_i && (action_i == ACT_LOAD)) begin
      // A load always restarts, abandoning any line in progress.
      cur_col_d     = x_start_i;
      cur_row_d     = y_start_i;
      col_err_d     = '0;
      row_err_d     = '0;
      abs_dx_d      = abs_dx_ld;
      abs_dy_d      = abs_dy_ld;
      span_d        = span_ld;
      col_dir_d     = col_dir_ld;
      row_dir_d     = row_dir_ld;
      points_left_d = {1'b0, span_ld} + ErrBits'(2);
      busy_d        = 1'b1;
    end else if (step_fire) begin
      if (col_sum > span_w) begin
        col_err_d = col_sum - span_w;
        cur_col_d = col_moved;
      end else begin
        col_err_d = col_sum;
      end
      if (row_sum > span_w) begin
        row_err_d = row_sum - span_w;
        cur_row_d = row_moved;
      end else begin
        row_err_d = row_sum;
      end
      points_left_d = pl_dec;
      busy_d        = (pl_dec != '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_col_q     <= '0;
      cur_row_q     <= '0;
      col_err_q     <= '0;
      row_err_q     <= '0;
      abs_dx_q      <= '0;
      abs_dy_q      <= '0;
      span_q        <= '0;
      col_dir_q     <= DIR_NONE;
      row_dir_q     <= DIR_NONE;
      points_left_q <= '0;
      busy_q        <= 1'b0;
    end else begin
      cur_col_q     <= cur_col_d;
      cur_row_q     <= cur_row_d;
      col_err_q     <= col_err_d;
      row_err_q     <= row_err_d;
      abs_dx_q      <= abs_dx_d;
      abs_dy_q      <= abs_dy_d;
      span_q        <= span_d;
      col_dir_q     <= col_dir_d;
      row_dir_q     <= row_dir_d;
      points_left_q <= points_left_d;
      busy_q        <= busy_d;
    end
  end

  assign pixel_x_o    = cur_col_q;
  assign pixel_y_o    = cur_row_q;
  assign stat_o.valid = step_fire;
  assign stat_o.last  = (points_left_q == ErrBits'(1));
  assign stat_o.busy  = busy_q;

endmodule

`default_nettype wire

### sv/lpg_skid.sv
// ----------------------------------------------------------------------------
// Line point generator result buffer
// Two-entry first-in first-out buffer between the core and the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module lpg_skid #(
  parameter int unsigned Width = 39
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             room_o,
  output logic             valid_o,
  output logic [Width-1:0] data_o,
  input  logic             pop_i
);

  logic [Width-1:0] slot_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       count_q, count_d;
  logic             pop;

  assign pop     = valid_o && pop_i;
  assign valid_o = (count_q != 2'd0);
  assign room_o  = (count_q != 2'd2);
  assign data_o  = slot_q[rd_ptr_q];
  assign count_d = count_q + {1'b0, push_i} - {1'b0, pop};

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      count_q <= count_d;
    end
  end

endmodule

`default_nettype wire

### sv/line_point_generator.sv
// ----------------------------------------------------------------------------
// Line point generator
// Error-accumulating line rasterizer, one pixel per step of an active line.
// ----------------------------------------------------------------------------
// Usage:
// An item on in_i either loads a new line (action load, endpoints taken from
// the item) or steps the current line (action step). A load produces no
// pixel and restarts the generator even in the middle of a line. Each step
// while a line is in progress produces one pixel on out_o in the current
// draw color; a step while idle is taken and dropped. A line of major span S
// gives S + 2 pixels, the first point twice, and the final one has last set.
// The user must write the draw color through cfg_we_i/cfg_wdata_i only while
// idle; the block does not enforce this. Throughput is one item per cycle
// while in_i.ready is high, set by the single state update per step. Each
// pixel is registered in a two-entry buffer, so one more item is taken while
// a pixel waits; when the buffer is full in_i.ready drops until out_o drains.
// Reset clears the line state, the color and the buffer; no line is active.
// ----------------------------------------------------------------------------
`default_nettype none

`include "line_point_generator_defines.svh"

module line_point_generator import lpg_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [COLOR_BITS-1:0] cfg_wdata_i,
  lpg_in_if.sink                in_i,
  lpg_out_if.source             out_o
);

  localparam int unsigned BufWidth = 2 * COORD_BITS + COLOR_BITS + 1;

  logic [COLOR_BITS-1:0] draw_color_q;
  logic                  room;
  logic                  take;
  logic [COORD_BITS-1:0] core_x, core_y;
  lpg_stat_t             stat;
  logic [BufWidth-1:0]   buf_in, buf_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      draw_color_q <= '0;
    end else if (cfg_we_i) begin
      draw_color_q <= cfg_wdata_i;
    end
  end

  assign in_i.ready = room;
  assign take       = in_i.valid && room;

  lpg_step #(
    .CoordBits (COORD_BITS)
  ) u_step (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .take_i    (take),
    .action_i  (in_i.action),
    .x_start_i (in_i.x_start),
    .y_start_i (in_i.y_start),
    .x_end_i   (in_i.x_end),
    .y_end_i   (in_i.y_end),
    .pixel_x_o (core_x),
    .pixel_y_o (core_y),
    .stat_o    (stat)
  );

  assign buf_in = {core_x, core_y, draw_color_q, stat.last};

  lpg_skid #(
    .Width (BufWidth)
  ) u_skid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (stat.valid),
    .data_i  (buf_in),
    .room_o  (room),
    .valid_o (out_o.valid),
    .data_o  (buf_out),
    .pop_i   (out_o.ready)
  );

  assign out_o.pixel_x     = buf_out[BufWidth-1 -: COORD_BITS];
  assign out_o.pixel_y     = buf_out[COLOR_BITS+COORD_BITS -: COORD_BITS];
  assign out_o.pixel_color = buf_out[COLOR_BITS -: COLOR_BITS];
  assign out_o.last        = buf_out[0];

  // A pixel is only produced when the buffer has room for it.
  `LPG_ASSERT_NOW(a_push_room, clk_i, rst_ni, stat.valid, room, "pixel pushed into full buffer")

  // The final pixel of a line leaves the core idle.
  `LPG_ASSERT_NEXT(a_last_idle, clk_i, rst_ni, stat.valid && stat.last, !stat.busy,
                   "core still busy after final pixel")

  // A pixel that is not the final one keeps the line going.
  `LPG_ASSERT_NEXT(a_mid_busy, clk_i, rst_ni, stat.valid && !stat.last, stat.busy,
                   "core went idle before final pixel")

  // A taken load always starts a line.
  `LPG_ASSERT_NEXT(a_load_busy, clk_i, rst_ni, take && (in_i.action == ACT_LOAD), stat.busy,
                   "load did not start a line")

endmodule

`default_nettype wire
